// ----- rtl/ifs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types and constants of the information frame stuffer.
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int unsigned IFS_QUEUE_DEPTH = 2;
    localparam int unsigned IFS_CFG_IDX_W   = 3;
    localparam logic [7:0]  IFS_STUFF_MASK  = 8'h20;

    typedef enum logic [IFS_CFG_IDX_W-1:0] {
        CFG_FLAG    = 3'd0,
        CFG_ESCAPE  = 3'd1,
        CFG_ADDRESS = 3'd2,
        CFG_CTL0    = 3'd3,
        CFG_CTL1    = 3'd4
    } ifs_cfg_idx_t;

    localparam logic [7:0] IFS_RST_FLAG    = 8'd126;
    localparam logic [7:0] IFS_RST_ESCAPE  = 8'd125;
    localparam logic [7:0] IFS_RST_ADDRESS = 8'd3;
    localparam logic [7:0] IFS_RST_CTL0    = 8'd0;
    localparam logic [7:0] IFS_RST_CTL1    = 8'd64;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       sequence_bit;
        logic       last_in_frame;
    } ifs_in_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } ifs_out_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] address_byte;
        logic [7:0] control_seq0;
        logic [7:0] control_seq1;
    } ifs_cfg_t;

    // one classified item, front to back
    typedef struct packed {
        logic       hdr;
        logic       seq;
        logic [7:0] data;
        logic       data_esc;
        logic       last;
        logic [7:0] check;
        logic       check_esc;
    } ifs_desc_t;

endpackage : ifs_pkg
`default_nettype wire

// ----- rtl/ifs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_front
// Accepts payload beats, tracks frame state and running XOR, classifies bytes.
// ----------------------------------------------------------------------------
module ifs_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ifs_pkg::ifs_cfg_t cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ifs_pkg::ifs_in_t  s_data,
    input  wire logic              q_full,
    output logic                   q_push,
    output ifs_pkg::ifs_desc_t     q_desc
);
    import ifs_pkg::*;

    logic       in_frame_reg, in_frame_next;
    logic [7:0] parity_reg, parity_next;
    logic [7:0] check;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign check   = parity_reg ^ s_data.payload_byte;

    always_comb begin
        q_desc.hdr       = !in_frame_reg;
        q_desc.seq       = s_data.sequence_bit;
        q_desc.data      = s_data.payload_byte;
        q_desc.data_esc  = (s_data.payload_byte == cfg.flag_byte) ||
                           (s_data.payload_byte == cfg.escape_byte);
        q_desc.last      = s_data.last_in_frame;
        q_desc.check     = check;
        q_desc.check_esc = (check == cfg.flag_byte) || (check == cfg.escape_byte);
    end

    always_comb begin
        in_frame_next = in_frame_reg;
        parity_next   = parity_reg;
        if (q_push) begin
            in_frame_next = !s_data.last_in_frame;
            parity_next   = s_data.last_in_frame ? 8'h00 : check;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            parity_reg   <= 8'h00;
        end else begin
            in_frame_reg <= in_frame_next;
            parity_reg   <= parity_next;
        end
    end

endmodule : ifs_front
`default_nettype wire

// ----- rtl/ifs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module ifs_queue #(
    parameter int unsigned DEPTH = ifs_pkg::IFS_QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ifs_pkg::ifs_desc_t push_desc,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output ifs_pkg::ifs_desc_t      head_desc
);
    import ifs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ifs_desc_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : ifs_queue
`default_nettype wire

// ----- rtl/ifs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_back
// Sequences header, stuffed payload, stuffed check and closing flag, one
// line byte per beat, into the output register.
// ----------------------------------------------------------------------------
module ifs_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ifs_pkg::ifs_cfg_t  cfg,
    input  wire logic               q_valid,
    input  wire ifs_pkg::ifs_desc_t q_desc,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ifs_pkg::ifs_out_t       m_data
);
    import ifs_pkg::*;

    typedef enum logic [9:0] {
        ST_NEW   = 10'b00_0000_0001,
        ST_FLAG  = 10'b00_0000_0010,
        ST_ADDR  = 10'b00_0000_0100,
        ST_CTL   = 10'b00_0000_1000,
        ST_HCS   = 10'b00_0001_0000,
        ST_DATA  = 10'b00_0010_0000,
        ST_DATA2 = 10'b00_0100_0000,
        ST_CHK   = 10'b00_1000_0000,
        ST_CHK2  = 10'b01_0000_0000,
        ST_CLOSE = 10'b10_0000_0000
    } ifs_step_t;

    ifs_step_t  step_reg, step_next, cur_step, after_step;
    logic       m_valid_reg, m_valid_next;
    ifs_out_t   out_reg, out_next;
    logic       load;
    logic       done;
    logic [7:0] ctl;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign ctl     = q_desc.seq ? cfg.control_seq1 : cfg.control_seq0;
    assign cur_step = (step_reg == ST_NEW) ? (q_desc.hdr ? ST_FLAG : ST_DATA) : step_reg;
    assign q_pop   = load && done;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        after_step         = ST_NEW;
        done               = 1'b0;
        out_next.line_byte = cfg.flag_byte;
        out_next.frame_end = 1'b0;
        unique case (cur_step)
            ST_FLAG: begin
                out_next.line_byte = cfg.flag_byte;
                after_step         = ST_ADDR;
            end
            ST_ADDR: begin
                out_next.line_byte = cfg.address_byte;
                after_step         = ST_CTL;
            end
            ST_CTL: begin
                out_next.line_byte = ctl;
                after_step         = ST_HCS;
            end
            ST_HCS: begin
                out_next.line_byte = cfg.address_byte ^ ctl;
                after_step         = ST_DATA;
            end
            ST_DATA: begin
                out_next.line_byte = q_desc.data_esc ? cfg.escape_byte : q_desc.data;
                if (q_desc.data_esc) begin
                    after_step = ST_DATA2;
                end else if (q_desc.last) begin
                    after_step = ST_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            ST_DATA2: begin
                out_next.line_byte = q_desc.data ^ IFS_STUFF_MASK;
                if (q_desc.last) begin
                    after_step = ST_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            ST_CHK: begin
                out_next.line_byte = q_desc.check_esc ? cfg.escape_byte : q_desc.check;
                after_step         = q_desc.check_esc ? ST_CHK2 : ST_CLOSE;
            end
            ST_CHK2: begin
                out_next.line_byte = q_desc.check ^ IFS_STUFF_MASK;
                after_step         = ST_CLOSE;
            end
            ST_CLOSE: begin
                out_next.line_byte = cfg.flag_byte;
                out_next.frame_end = 1'b1;
                done               = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
        out_next.run_end = done;
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            step_next    = after_step;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_NEW;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(step_reg))
        else $error("step register not one-hot");

    a_pop_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop with empty queue");

    a_close_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> m_data.run_end)
        else $error("closing flag not last byte of run");

    a_mid_item_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg != ST_NEW) |-> q_valid)
        else $error("item lost from queue mid-sequence");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule : ifs_back
`default_nettype wire

// ----- rtl/info_frame_stuffer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// info_frame_stuffer_top
// Information frame byte-stuffing framer.
// ----------------------------------------------------------------------------
// Each accepted payload beat yields 1 to 9 line-byte beats: a 4-byte header
// (flag, address, control, address^control) on a frame's first byte, the
// byte itself (2 beats if it matches flag or escape), and on the last byte
// the stuffed payload XOR (1 or 2 beats) plus the closing flag. The output
// register moves one line byte per cycle while m_ready is high and an item
// waits; the front keeps accepting while up to QUEUE_DEPTH classified items
// wait for the sequencer. Registers are written through the cfg port, always
// ready; write only while the block is idle.
// ----------------------------------------------------------------------------
module info_frame_stuffer_top #(
    parameter int unsigned QUEUE_DEPTH = ifs_pkg::IFS_QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ifs_pkg::ifs_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ifs_pkg::ifs_out_t                      m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ifs_pkg::IFS_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                        cfg_data
);
    import ifs_pkg::*;

    ifs_cfg_t  cfg_reg, cfg_next;
    ifs_desc_t push_desc, head_desc;
    logic      q_push, q_full, q_pop, q_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FLAG:    cfg_next.flag_byte    = cfg_data;
                CFG_ESCAPE:  cfg_next.escape_byte  = cfg_data;
                CFG_ADDRESS: cfg_next.address_byte = cfg_data;
                CFG_CTL0:    cfg_next.control_seq0 = cfg_data;
                CFG_CTL1:    cfg_next.control_seq1 = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte    <= IFS_RST_FLAG;
            cfg_reg.escape_byte  <= IFS_RST_ESCAPE;
            cfg_reg.address_byte <= IFS_RST_ADDRESS;
            cfg_reg.control_seq0 <= IFS_RST_CTL0;
            cfg_reg.control_seq1 <= IFS_RST_CTL1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ifs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_desc  (push_desc)
    );

    ifs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (head_desc)
    );

    ifs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_desc  (head_desc),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule : info_frame_stuffer_top
`default_nettype wire
